/* sv/tdtv_pkg.sv */
`default_nettype none

package tdtv_pkg;

    // Type codes carried in value_type
    localparam logic [3:0] TYPE_U8     = 4'd0;
    localparam logic [3:0] TYPE_U16    = 4'd1;
    localparam logic [3:0] TYPE_U32    = 4'd2;
    localparam logic [3:0] TYPE_U64    = 4'd3;
    localparam logic [3:0] TYPE_S8     = 4'd4;
    localparam logic [3:0] TYPE_S16    = 4'd5;
    localparam logic [3:0] TYPE_S32    = 4'd6;
    localparam logic [3:0] TYPE_S64    = 4'd7;
    localparam logic [3:0] TYPE_FLOAT  = 4'd8;
    localparam logic [3:0] TYPE_DOUBLE = 4'd9;
    localparam logic [3:0] TYPE_CHAR   = 4'd10;
    localparam logic [3:0] TYPE_STRING = 4'd11;
    localparam logic [3:0] TYPE_BOOL   = 4'd12;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Largest magnitude that can still take another decimal digit
    localparam logic [63:0] MAG_DIV10_LIMIT = 64'd1844674407370955161;
    localparam logic [3:0]  MAG_LAST_DIGIT  = 4'd5;

    localparam logic [2:0] POS_MAX = 3'd7;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       empty_token;
        logic [3:0] value_type;
    } in_t;

    typedef struct packed {
        logic        is_valid;
        logic [63:0] value_bits;
    } out_t;

    // Everything known about a finished token
    typedef struct packed {
        logic        empty;
        logic [3:0]  vtype;
        logic        minus_seen;
        logic [2:0]  last_pos;
        logic        digit_seen;
        logic        dot_seen;
        logic        bad_char;
        logic        mag_ovf;
        logic        true_match;
        logic        false_match;
        logic [7:0]  first_byte;
        logic [63:0] magnitude;
    } token_sum_t;

    function automatic logic [7:0] word_true_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h74; // t
            2'd1:    ch = 8'h72; // r
            2'd2:    ch = 8'h75; // u
            default: ch = 8'h65; // e
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] word_false_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h66; // f
            3'd1:    ch = 8'h61; // a
            3'd2:    ch = 8'h6C; // l
            3'd3:    ch = 8'h73; // s
            default: ch = 8'h65; // e
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* sv/typed_decimal_token_validator_top.sv */
// Path: the last character of a token passes the input register, the token accumulator
//   and the result register, in that order, before m_valid rises for the token.
// Throughput: one character per cycle; each stage advances when the one after it is
//   empty or moving, so a waiting result stalls s_ready only once a finished token and
//   one more character are held behind it.
// Reset: aresetn is synchronous, active low; it empties all stages and clears the token.
`default_nettype none

module typed_decimal_token_validator_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tdtv_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tdtv_pkg::out_t      m_data
);

    // Input register
    logic           in_valid_reg, in_valid_next;
    tdtv_pkg::in_t  in_data_reg;

    // Result register
    logic           out_valid_reg, out_valid_next;
    tdtv_pkg::out_t out_data_reg;

    logic                 sum_valid;
    tdtv_pkg::token_sum_t sum;
    tdtv_pkg::out_t       result;

    logic adv_out;   // result register may load
    logic adv_acc;   // accumulator may consume the held character

    // Advance each stage when the stage after it is empty or draining
    assign adv_out = !out_valid_reg || m_ready;
    assign adv_acc = !sum_valid || adv_out;
    assign s_ready = !in_valid_reg || adv_acc;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = adv_out ? sum_valid : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv_out && sum_valid) begin
            out_data_reg <= result;
        end
    end

    // Fold each character into the running token state; emit a summary on the last one or an empty token
    tdtv_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_data_reg),
        .advance    (adv_acc),
        .sum_valid  (sum_valid),
        .sum        (sum)
    );

    // Range checks and value formation for the finished token
    tdtv_final u_final (
        .sum    (sum),
        .result (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // An empty result register never stalls the input side
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while result register empty");

    // A rejected token carries a zero value
    a_invalid_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_valid |-> m_data.value_bits == 64'd0)
        else $error("invalid result with nonzero value");

    // A finished token summary is not dropped while the result side stalls
    a_summary_held: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid && !adv_out |=> sum_valid && $stable(sum))
        else $error("token summary lost under stall");

endmodule

`default_nettype wire

/* sv/tdtv_accum.sv */
`default_nettype none

module tdtv_accum (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    input  wire tdtv_pkg::in_t         item,
    input  wire logic                  advance,
    output logic                       sum_valid,
    output tdtv_pkg::token_sum_t       sum
);

    logic [3:0]  held_type_reg,   held_type_next;
    logic        minus_reg,       minus_next;
    logic [2:0]  pos_reg,         pos_next;
    logic        digit_reg,       digit_next;
    logic        dot_reg,         dot_next;
    logic        bad_reg,         bad_next;
    logic [63:0] mag_reg,         mag_next;
    logic        ovf_reg,         ovf_next;
    logic        true_reg,        true_next;
    logic        false_reg,       false_next;
    logic [7:0]  first_reg,       first_next;
    logic        sum_valid_reg,   sum_valid_next;
    tdtv_pkg::token_sum_t sum_reg, sum_next;

    logic        step;
    logic        done;
    logic        is_digit;
    logic [3:0]  digit;
    logic [7:0]  lower;
    logic [63:0] mag_x10;

    assign step = item_valid && advance;
    assign done = item.last_char || item.empty_token;

    always_comb begin
        is_digit = (item.character >= tdtv_pkg::CH_ZERO) &&
                   (item.character <= tdtv_pkg::CH_NINE);
        digit    = item.character[3:0];
        mag_x10  = {mag_reg[60:0], 3'b000} + {mag_reg[62:0], 1'b0};
        lower    = ((item.character >= tdtv_pkg::CH_UP_A) &&
                    (item.character <= tdtv_pkg::CH_UP_Z)) ?
                   item.character + tdtv_pkg::CASE_OFS : item.character;

        held_type_next = (pos_reg == 3'd0) ? item.value_type : held_type_reg;
        first_next     = (pos_reg == 3'd0) ? item.character  : first_reg;
        minus_next     = minus_reg;
        digit_next     = digit_reg;
        dot_next       = dot_reg;
        bad_next       = bad_reg;
        mag_next       = mag_reg;
        ovf_next       = ovf_reg;

        if (is_digit) begin
            digit_next = 1'b1;
            if (!ovf_reg) begin
                if ((mag_reg > tdtv_pkg::MAG_DIV10_LIMIT) ||
                    ((mag_reg == tdtv_pkg::MAG_DIV10_LIMIT) &&
                     (digit > tdtv_pkg::MAG_LAST_DIGIT))) begin
                    ovf_next = 1'b1;
                end else begin
                    mag_next = mag_x10 + {60'd0, digit};
                end
            end
        end else if ((pos_reg == 3'd0) && ((item.character == tdtv_pkg::CH_PLUS) ||
                                           (item.character == tdtv_pkg::CH_MINUS))) begin
            if (item.character == tdtv_pkg::CH_MINUS) begin
                minus_next = 1'b1;
            end
        end else if ((item.character == tdtv_pkg::CH_DOT) && !dot_reg) begin
            dot_next = 1'b1;
        end else begin
            bad_next = 1'b1;
        end

        true_next  = true_reg && (pos_reg < 3'd4) &&
                     (lower == tdtv_pkg::word_true_char(pos_reg[1:0]));
        false_next = false_reg && (pos_reg < 3'd5) &&
                     (lower == tdtv_pkg::word_false_char(pos_reg));
        pos_next   = (pos_reg < tdtv_pkg::POS_MAX) ? pos_reg + 3'd1 : tdtv_pkg::POS_MAX;

        sum_next.empty       = item.empty_token;
        sum_next.vtype       = item.empty_token ? item.value_type : held_type_next;
        sum_next.minus_seen  = minus_next;
        sum_next.last_pos    = pos_reg;
        sum_next.digit_seen  = digit_next;
        sum_next.dot_seen    = dot_next;
        sum_next.bad_char    = bad_next;
        sum_next.mag_ovf     = ovf_next;
        sum_next.true_match  = true_next;
        sum_next.false_match = false_next;
        sum_next.first_byte  = first_next;
        sum_next.magnitude   = mag_next;

        sum_valid_next = advance ? (step && done) : sum_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_type_reg <= '0;
            minus_reg     <= 1'b0;
            pos_reg       <= '0;
            digit_reg     <= 1'b0;
            dot_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            true_reg      <= 1'b1;
            false_reg     <= 1'b1;
            first_reg     <= '0;
            sum_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            if (step) begin
                if (done) begin
                    // clear for the next token
                    held_type_reg <= '0;
                    minus_reg     <= 1'b0;
                    pos_reg       <= '0;
                    digit_reg     <= 1'b0;
                    dot_reg       <= 1'b0;
                    bad_reg       <= 1'b0;
                    mag_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    true_reg      <= 1'b1;
                    false_reg     <= 1'b1;
                    first_reg     <= '0;
                end else begin
                    held_type_reg <= held_type_next;
                    minus_reg     <= minus_next;
                    pos_reg       <= pos_next;
                    digit_reg     <= digit_next;
                    dot_reg       <= dot_next;
                    bad_reg       <= bad_next;
                    mag_reg       <= mag_next;
                    ovf_reg       <= ovf_next;
                    true_reg      <= true_next;
                    false_reg     <= false_next;
                    first_reg     <= first_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && done) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

`default_nettype wire

/* sv/tdtv_final.sv */
`default_nettype none

module tdtv_final (
    input  wire tdtv_pkg::token_sum_t sum,
    output tdtv_pkg::out_t            result
);

    logic [63:0] mag;
    logic        above_n;
    logic        above_m;
    logic        low_m;
    logic        int_ok;
    logic        fits_u;
    logic        fits_pos;
    logic        fits_neg;
    logic        signed_ok;
    logic        is_one;
    logic        is_zero;

    assign mag = sum.magnitude;

    always_comb begin
        // above_n: magnitude needs more than n bits; above_m: more than n-1;
        // low_m: any of the low n-1 bits set
        case (sum.vtype[1:0])
            2'd0: begin
                above_n = |mag[63:8];
                above_m = |mag[63:7];
                low_m   = |mag[6:0];
            end
            2'd1: begin
                above_n = |mag[63:16];
                above_m = |mag[63:15];
                low_m   = |mag[14:0];
            end
            2'd2: begin
                above_n = |mag[63:32];
                above_m = |mag[63:31];
                low_m   = |mag[30:0];
            end
            default: begin
                above_n = 1'b0;
                above_m = mag[63];
                low_m   = |mag[62:0];
            end
        endcase

        int_ok    = sum.digit_seen && !sum.bad_char && !sum.dot_seen && !sum.mag_ovf;
        fits_u    = !above_n;
        fits_pos  = !above_m;
        fits_neg  = !above_m || (!above_n && !low_m);
        signed_ok = int_ok && (sum.minus_seen ? fits_neg : fits_pos);

        is_one  = ((sum.last_pos == 3'd0) && (sum.first_byte == tdtv_pkg::CH_ONE)) ||
                  ((sum.last_pos == 3'd3) && sum.true_match);
        is_zero = ((sum.last_pos == 3'd0) && (sum.first_byte == tdtv_pkg::CH_ZERO)) ||
                  ((sum.last_pos == 3'd4) && sum.false_match);

        result = '0;
        if (sum.empty) begin
            result.is_valid = (sum.vtype == tdtv_pkg::TYPE_CHAR) ||
                              (sum.vtype == tdtv_pkg::TYPE_STRING);
        end else begin
            unique case (sum.vtype) inside
                [tdtv_pkg::TYPE_U8 : tdtv_pkg::TYPE_U64]: begin
                    result.is_valid = int_ok && !sum.minus_seen && fits_u;
                    if (result.is_valid) begin
                        result.value_bits = mag;
                    end
                end
                [tdtv_pkg::TYPE_S8 : tdtv_pkg::TYPE_S64]: begin
                    result.is_valid = signed_ok;
                    if (signed_ok) begin
                        result.value_bits = sum.minus_seen ? (64'd0 - mag) : mag;
                    end
                end
                tdtv_pkg::TYPE_FLOAT, tdtv_pkg::TYPE_DOUBLE: begin
                    result.is_valid = sum.digit_seen && !sum.bad_char;
                end
                tdtv_pkg::TYPE_CHAR: begin
                    result.is_valid   = 1'b1;
                    result.value_bits = {56'd0, sum.first_byte};
                end
                tdtv_pkg::TYPE_STRING: begin
                    result.is_valid = 1'b1;
                end
                tdtv_pkg::TYPE_BOOL: begin
                    result.is_valid   = is_one || is_zero;
                    result.value_bits = {63'd0, is_one};
                end
                default: begin
                    result = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* verif/tb_typed_decimal_token_validator_top.sv */
`timescale 1ns / 100ps

module tb_typed_decimal_token_validator_top;
    import tdtv_pkg::*;

    // Cycles with no transfer on either channel before the run is declared hung.
    // The longest correct pause is a capped sender gap plus a few pipeline stages,
    // or a receiver stall run at 67 percent, both far below this.
    localparam int STALL_LIMIT  = 1000;
    // Pipeline depth is three stages; allow a little more before the final verdict.
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_GAP      = 40;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    // Idle rates in percent of cycles, changed between test phases.
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    int error_count = 0;
    int chars_sent  = 0;
    int results_seen = 0;

    // Verdicts the token judge has worked out, oldest first.
    out_t pending_verdicts[$];

    // Characters of the token being built by a test task.
    logic [7:0] token_buf[$];

    // Judge state: a copy of what the block tracks for the token in progress.
    logic [3:0]  tok_type;
    logic        tok_minus;
    logic [2:0]  tok_pos;
    logic        tok_digit;
    logic        tok_dot;
    logic        tok_bad;
    logic [63:0] tok_mag;
    logic        tok_ovf;
    logic        tok_true;
    logic        tok_false;
    logic [7:0]  tok_first;

    string true_word  = "true";
    string false_word = "false";

    typed_decimal_token_validator_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t result %0d: %s", $realtime, results_seen, what);
        error_count++;
    endtask

    // Compare each result transfer against the oldest pending verdict.
    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result valid=%0b value=%h",
                                          m_data.is_valid, m_data.value_bits));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.is_valid !== want.is_valid) begin
                    report_mismatch($sformatf("is_valid %0b, want %0b",
                                              m_data.is_valid, want.is_valid));
                end
                if (m_data.value_bits !== want.value_bits) begin
                    report_mismatch($sformatf("value_bits %h, want %h",
                                              m_data.value_bits, want.value_bits));
                end
            end
            results_seen++;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void clear_token_state();
        tok_type  = '0;
        tok_minus = 1'b0;
        tok_pos   = '0;
        tok_digit = 1'b0;
        tok_dot   = 1'b0;
        tok_bad   = 1'b0;
        tok_mag   = '0;
        tok_ovf   = 1'b0;
        tok_true  = 1'b1;
        tok_false = 1'b1;
        tok_first = '0;
    endfunction

    // Advance the token state by one accepted character; at the end of a token,
    // queue the verdict the block must give.
    function automatic void judge_token_char(input in_t item);
        logic [7:0]  c;
        logic [7:0]  lower;
        logic [3:0]  t;
        logic [2:0]  p;
        logic [63:0] digit;
        logic [63:0] uns_max;
        logic [63:0] neg_lim;
        logic        ok;
        logic        is_one;
        logic        is_zero;
        int          bits;
        out_t        res;

        c   = item.character;
        p   = tok_pos;
        res = '0;

        // An empty token stands alone and drops anything partly received.
        if (item.empty_token) begin
            res.is_valid = (item.value_type == TYPE_CHAR) || (item.value_type == TYPE_STRING);
            pending_verdicts.push_back(res);
            clear_token_state();
            return;
        end

        // Latch the type code and first byte with the first character only.
        if (p == 0) begin
            tok_type  = item.value_type;
            tok_first = c;
        end
        t = tok_type;

        if (c >= CH_ZERO && c <= CH_NINE) begin
            digit     = 64'(c - CH_ZERO);
            tok_digit = 1'b1;
            // Freeze the magnitude once another digit would not fit in 64 bits.
            if (!tok_ovf) begin
                if (tok_mag > MAG_DIV10_LIMIT ||
                    (tok_mag == MAG_DIV10_LIMIT && digit > 64'(MAG_LAST_DIGIT))) begin
                    tok_ovf = 1'b1;
                end else begin
                    tok_mag = tok_mag * 64'd10 + digit;
                end
            end
        end else if (p == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) begin
                tok_minus = 1'b1;
            end
        end else if (c == CH_DOT && !tok_dot) begin
            tok_dot = 1'b1;
        end else begin
            tok_bad = 1'b1;
        end

        // Fold only ASCII capitals; bytes above 127 pass through untouched.
        lower = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
        if (!(p < 4 && lower == true_word[p])) begin
            tok_true = 1'b0;
        end
        if (!(p < 5 && lower == false_word[p])) begin
            tok_false = 1'b0;
        end

        tok_pos = (p < POS_MAX) ? p + 3'd1 : POS_MAX;

        if (!item.last_char) begin
            return;
        end

        if (t <= TYPE_S64) begin
            ok = tok_digit && !tok_bad && !tok_dot && !tok_ovf;
            if (t <= TYPE_U64) begin
                case (t)
                    TYPE_U8:  uns_max = 64'hFF;
                    TYPE_U16: uns_max = 64'hFFFF;
                    TYPE_U32: uns_max = 64'hFFFF_FFFF;
                    default:  uns_max = '1;
                endcase
                ok = ok && !tok_minus && (tok_mag <= uns_max);
                if (ok) begin
                    res.value_bits = tok_mag;
                end
            end else begin
                // The negative side reaches one further than the positive side.
                bits    = 8 << (t - TYPE_S8);
                neg_lim = 64'd1 << (bits - 1);
                ok = ok && (tok_mag <= (tok_minus ? neg_lim : neg_lim - 64'd1));
                if (ok) begin
                    res.value_bits = tok_minus ? 64'd0 - tok_mag : tok_mag;
                end
            end
            res.is_valid = ok;
        end else if (t == TYPE_FLOAT || t == TYPE_DOUBLE) begin
            res.is_valid = tok_digit && !tok_bad;
        end else if (t == TYPE_CHAR) begin
            res.is_valid   = 1'b1;
            res.value_bits = {56'd0, tok_first};
        end else if (t == TYPE_STRING) begin
            res.is_valid = 1'b1;
        end else if (t == TYPE_BOOL) begin
            is_one  = (p == 0 && tok_first == CH_ONE) || (p == 3 && tok_true);
            is_zero = (p == 0 && tok_first == CH_ZERO) || (p == 4 && tok_false);
            res.is_valid   = is_one || is_zero;
            res.value_bits = is_one ? 64'd1 : 64'd0;
        end
        // Type codes past bool fall through: never valid, value zero.

        pending_verdicts.push_back(res);
        clear_token_state();
    endfunction

    // Send one character. Idle first at the sender's rate, then hold valid and
    // the payload until the transfer happens, and judge it at that edge.
    task automatic send_char(input in_t item);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        judge_token_char(item);
        chars_sent++;
    endtask

    // Send the built token; an empty buffer goes out as an empty token.
    // Type codes after the first character are noise the block must ignore.
    task automatic send_token(input logic [3:0] vtype);
        in_t item;
        if (token_buf.size() == 0) begin
            item.character   = 8'($urandom_range(0, 255));
            item.last_char   = 1'($urandom_range(0, 1));
            item.empty_token = 1'b1;
            item.value_type  = vtype;
            send_char(item);
        end
        for (int i = 0; i < token_buf.size(); i++) begin
            item.character   = token_buf[i];
            item.last_char   = (i == token_buf.size() - 1);
            item.empty_token = 1'b0;
            item.value_type  = (i == 0) ? vtype : 4'($urandom_range(0, 15));
            send_char(item);
        end
        token_buf.delete();
    endtask

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            token_buf.push_back(s[i]);
        end
    endfunction

    // Drop one stray character somewhere into the token.
    function automatic void corrupt_token();
        string junk;
        int    idx;
        junk = ".+- a,x0";
        idx  = $urandom_range(0, token_buf.size());
        if ($urandom_range(0, 3) == 0) begin
            token_buf.insert(idx, 8'($urandom_range(0, 255)));
        end else begin
            token_buf.insert(idx, junk[$urandom_range(0, junk.len() - 1)]);
        end
    endfunction

    // Range extremes for u8 and s8, each type family, and the named corner cases.
    task automatic test_directed();
        in_t item;
        append_text("255");   send_token(TYPE_U8);   // u8 maximum
        append_text("-0");    send_token(TYPE_S8);   // minus zero is a valid zero
        append_text("-128");  send_token(TYPE_S8);   // s8 minimum
        send_token(TYPE_CHAR);                       // empty token passes for char
        send_token(TYPE_U8);                         // empty token fails for numbers
        append_text("TRUE");  send_token(TYPE_BOOL); // bool word in capitals
        append_text("0");     send_token(TYPE_BOOL);
        append_text("1.5");   send_token(TYPE_FLOAT);
        append_text(".");     send_token(TYPE_DOUBLE); // a dot without digits
        append_text("z");     send_token(TYPE_CHAR);
        append_text("+7");    send_token(TYPE_S16);

        // A zero byte is an ordinary non-digit.
        item = '{character: 8'h00, last_char: 1'b1, empty_token: 1'b0, value_type: TYPE_U8};
        send_char(item);
        // High byte with a type code past bool: never valid.
        item = '{character: 8'hFF, last_char: 1'b1, empty_token: 1'b0, value_type: 4'hF};
        send_char(item);
        // Abandon a partial token with an empty one.
        item = '{character: CH_NINE, last_char: 1'b0, empty_token: 1'b0,
                 value_type: TYPE_U8};
        send_char(item);
        item = '{character: 8'h5A, last_char: 1'b0, empty_token: 1'b1,
                 value_type: TYPE_STRING};
        send_char(item);
    endtask

    // Integer tokens: range edges on both sides, random values, magnitudes
    // past 64 bits, stray signs, leading zeros and occasional junk.
    task automatic test_integer_tokens(input int budget);
        int          stop;
        int          kind;
        int          w;
        logic [3:0]  vtype;
        logic        is_signed;
        logic        minus;
        logic [64:0] mag;
        logic [64:0] lim;
        string       digits;
        stop = chars_sent + budget;
        while (chars_sent < stop) begin
            vtype     = 4'($urandom_range(TYPE_U8, TYPE_S64));
            is_signed = (vtype >= TYPE_S8);
            w         = 8 << vtype[1:0];
            lim       = is_signed ? (65'd1 << (w - 1)) : (65'd1 << w);
            minus     = is_signed ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
            kind      = $urandom_range(0, 9);
            digits    = "";
            case (kind)
                0: mag = (is_signed && minus) ? lim : lim - 65'd1;   // last valid
                1: mag = (is_signed && minus) ? lim + 65'd1 : lim;   // first invalid
                2: mag = '0;
                3: mag = {1'b0, $urandom, $urandom} & ((65'd1 << w) - 65'd1);
                4: mag = 65'($urandom_range(0, 999));
                5: begin
                    // Long digit run that mostly overflows the magnitude.
                    digits = $sformatf("%0d", $urandom_range(1, 9));
                    repeat ($urandom_range(19, 23)) begin
                        digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
                    end
                end
                default: mag = {1'b0, $urandom, $urandom} % lim;
            endcase
            if (digits == "") begin
                digits = $sformatf("%0d", mag);
            end
            if (minus) begin
                append_text("-");
            end else if ($urandom_range(0, 9) == 0) begin
                append_text("+");
            end
            if ($urandom_range(0, 9) == 0) begin
                append_text("00");
            end
            append_text(digits);
            if ($urandom_range(0, 99) < 12) begin
                corrupt_token();
            end
            send_token(vtype);
        end
    endtask

    // Float and double: sign, digits, at most one dot; sometimes two dots,
    // no digits at all, or junk.
    task automatic test_real_tokens(input int budget);
        int stop;
        stop = chars_sent + budget;
        while (chars_sent < stop) begin
            case ($urandom_range(0, 3))
                0: append_text("-");
                1: append_text("+");
                default: ;
            endcase
            repeat ($urandom_range(0, 4)) append_text($sformatf("%0d", $urandom_range(0, 9)));
            if ($urandom_range(0, 9) < 7) begin
                append_text(".");
            end
            repeat ($urandom_range(0, 4)) append_text($sformatf("%0d", $urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0) begin
                append_text(".");
            end
            if ($urandom_range(0, 9) == 0) begin
                corrupt_token();
            end
            send_token($urandom_range(0, 1) ? TYPE_FLOAT : TYPE_DOUBLE);
        end
    endtask

    // Bool words in mixed case, near misses and digit forms.
    task automatic test_bool_tokens(input int budget);
        int    stop;
        int    pick;
        string words[16];
        words = '{"true", "false", "0", "1", "tru", "truee", "fals", "falsey",
                  "2", "10", "t", "f", "yes", "+1", "rue", ""};
        stop = chars_sent + budget;
        while (chars_sent < stop) begin
            // Favor the words that should pass.
            pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            append_text(words[pick]);
            foreach (token_buf[i]) begin
                if (token_buf[i] >= 8'h61 && token_buf[i] <= 8'h7A && $urandom_range(0, 1)) begin
                    token_buf[i] = token_buf[i] - CASE_OFS;
                end
            end
            if (token_buf.size() != 0 && $urandom_range(0, 19) == 0) begin
                token_buf[$urandom_range(0, token_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_token(TYPE_BOOL);
        end
    endtask

    // Raw noise: any byte, any type code, empty tokens dropped in mid-token.
    // Char and string tokens get most of their coverage here.
    task automatic test_noise_tokens(input int budget);
        int         stop;
        int         len;
        logic [3:0] vtype;
        in_t        item;
        string      hot;
        hot  = "0123456789+-.tTfFrRuUeEaAlLsS";
        stop = chars_sent + budget;
        while (chars_sent < stop) begin
            len   = $urandom_range(1, 10);
            vtype = 4'($urandom_range(0, 15));
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 1)) begin
                    item.character = hot[$urandom_range(0, hot.len() - 1)];
                end else begin
                    item.character = 8'($urandom_range(0, 255));
                end
                item.empty_token = ($urandom_range(0, 99) < 4);
                item.last_char   = (k == len - 1) ||
                                   (item.empty_token && $urandom_range(0, 1));
                item.value_type  = (k == 0) ? vtype : 4'($urandom_range(0, 15));
                send_char(item);
            end
        end
    endtask

    initial begin
        clear_token_state();

        // Hold reset at the start, then release it for good.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle_pct   = 28;
        receiver_idle_pct = 67;
        test_directed();

        // Swap the idle rates each phase; the last phase runs at full rate.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 28;
                    receiver_idle_pct = 67;
                end
                1: begin
                    sender_idle_pct   = 67;
                    receiver_idle_pct = 28;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            test_integer_tokens(180);
            test_real_tokens(70);
            test_bool_tokens(70);
            test_noise_tokens(100);
        end

        // Drop valid after the last transfer, drain, then wait DRAIN_CYCLES for stray
        // results to show up.
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
